### rtl/ifig_pkg.sv
`timescale 1ns / 1ps

package ifig_pkg;

    localparam int CFG_W            = 7;
    localparam int VERTEX_W         = 16;
    localparam int FACE_NUM_W       = 17;
    localparam int SIDE_W           = 3;
    localparam int SIDES            = 5;
    localparam int IN_DATA_W        = 8;
    localparam int OUT_DATA_W       = 72;
    localparam int MAX_DIVISIONS_DEF = 64;

    typedef struct packed {
        logic valid;
        logic restart;
    } item_ctl_t;

    typedef struct packed {
        logic [VERTEX_W-1:0]   vertex_a;
        logic [VERTEX_W-1:0]   vertex_b;
        logic [VERTEX_W-1:0]   vertex_c;
        logic [FACE_NUM_W-1:0] face_number;
        logic                  last_face;
    } face_t;

endpackage

### rtl/ifig_in_stage.sv
`timescale 1ns / 1ps

module ifig_in_stage
    import ifig_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [IN_DATA_W-1:0] s_axis_tdata,   // [0] restart, rest zero
    input  logic                 advance,
    output item_ctl_t            item
);

    logic valid_reg;
    logic valid_next;
    logic restart_reg;
    logic accept;

    assign s_axis_tready = !valid_reg || advance;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // hold the payload until the sequencer takes it
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            restart_reg <= s_axis_tdata[0];
        end
    end

    assign item.valid   = valid_reg;
    assign item.restart = restart_reg;

endmodule

### rtl/ifig_seq.sv
`timescale 1ns / 1ps

module ifig_seq
    import ifig_pkg::*;
#(
    parameter int MAX_DIVISIONS = MAX_DIVISIONS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_data,
    input  item_ctl_t        item,
    input  logic             advance,
    output logic             fire,
    output logic             res_valid,
    output face_t            res_face
);

    localparam int DIV_W  = $clog2(MAX_DIVISIONS + 1);
    localparam int STEP_W = $clog2(2 * MAX_DIVISIONS + 1);
    localparam int IDX_W  = $clog2(5 * MAX_DIVISIONS + 2);

    typedef enum logic [2:0] {
        SEC_TOP,
        SEC_UPPER,
        SEC_MIDDLE,
        SEC_LOWER,
        SEC_BOTTOM
    } section_t;

    function automatic logic [IDX_W-1:0] ring_pos(input logic [IDX_W-1:0] k,
                                                  input logic [IDX_W-1:0] cnt);
        return (k == '0) ? cnt - 1'b1 : k - 1'b1;
    endfunction

    section_t              sec_reg,    sec_next,    sec_cur;
    logic [DIV_W-1:0]      ring_reg,   ring_next,   ring_cur;
    logic [SIDE_W-1:0]     side_reg,   side_next,   side_cur;
    logic [STEP_W-1:0]     step_reg,   step_next,   step_cur;
    logic                  second_reg, second_next, second_cur;
    logic [VERTEX_W-1:0]   lo_reg,     lo_next,     lo_cur;
    logic [VERTEX_W-1:0]   hi_reg,     hi_next,     hi_cur;
    logic [FACE_NUM_W-1:0] faces_reg,  faces_next,  faces_cur;
    logic                  fin_reg,    fin_next,    fin_cur;
    logic [DIV_W-1:0]      n_reg,      n_next;

    logic [DIV_W-1:0]      ml, mh;
    logic [STEP_W-1:0]     half;
    logic                  par;
    logic [IDX_W-1:0]      p, q, cl, ch;
    logic [IDX_W-1:0]      lo_p, lo_p1, hi_q, hi_q1;
    logic [VERTEX_W-1:0]   v_lo_p, v_lo_p1, v_hi_q, v_hi_q1;
    logic [VERTEX_W-1:0]   e_inc, e_wrap;
    logic [STEP_W-1:0]     step_inc;
    logic                  side_last;
    logic                  in_band;

    assign fire      = item.valid && advance;
    assign cfg_ready = 1'b1;

    // a restart item begins from the reset position of the list
    always_comb
    begin
        sec_cur    = item.restart ? SEC_TOP : sec_reg;
        ring_cur   = item.restart ? '0 : ring_reg;
        side_cur   = item.restart ? '0 : side_reg;
        step_cur   = item.restart ? '0 : step_reg;
        second_cur = item.restart ? 1'b0 : second_reg;
        lo_cur     = item.restart ? '0 : lo_reg;
        hi_cur     = item.restart ? VERTEX_W'(1) : hi_reg;
        faces_cur  = item.restart ? '0 : faces_reg;
        fin_cur    = item.restart ? 1'b0 : fin_reg;
    end

    always_comb
    begin
        if (cfg_data == '0)
        begin
            n_next = DIV_W'(1);
        end
        else if (32'(cfg_data) > 32'(MAX_DIVISIONS))
        begin
            n_next = DIV_W'(MAX_DIVISIONS);
        end
        else
        begin
            n_next = DIV_W'(cfg_data);
        end
    end

    // ring geometry of the current strip
    always_comb
    begin
        unique case (sec_cur)
            SEC_UPPER:
            begin
                ml = ring_cur;
                mh = ring_cur + 1'b1;
            end
            SEC_LOWER:
            begin
                ml = ring_cur + 1'b1;
                mh = ring_cur;
            end
            SEC_MIDDLE:
            begin
                ml = n_reg;
                mh = n_reg;
            end
            default:
            begin
                ml = '0;
                mh = '0;
            end
        endcase
        in_band = (sec_cur == SEC_MIDDLE);
        half    = in_band ? step_cur : (step_cur >> 1);
        par     = in_band ? second_cur : step_cur[0];
        p       = IDX_W'(side_cur) * IDX_W'(ml) + IDX_W'(half);
        q       = IDX_W'(side_cur) * IDX_W'(mh) + IDX_W'(half);
        cl      = (IDX_W'(ml) << 2) + IDX_W'(ml);
        ch      = (IDX_W'(mh) << 2) + IDX_W'(mh);
        lo_p    = ring_pos(p, cl);
        lo_p1   = ring_pos(p + 1'b1, cl);
        hi_q    = ring_pos(q, ch);
        hi_q1   = ring_pos(q + 1'b1, ch);
        v_lo_p  = lo_cur + VERTEX_W'(lo_p);
        v_lo_p1 = lo_cur + VERTEX_W'(lo_p1);
        v_hi_q  = hi_cur + VERTEX_W'(hi_q);
        v_hi_q1 = hi_cur + VERTEX_W'(hi_q1);
    end

    assign side_last = (side_cur >= SIDE_W'(SIDES - 1));
    assign e_inc     = VERTEX_W'(side_cur) + VERTEX_W'(1);
    assign e_wrap    = side_last ? '0 : e_inc;
    assign step_inc  = step_cur + 1'b1;

    always_comb
    begin
        sec_next    = sec_cur;
        ring_next   = ring_cur;
        side_next   = side_cur;
        step_next   = step_cur;
        second_next = second_cur;
        lo_next     = lo_cur;
        hi_next     = hi_cur;
        faces_next  = faces_cur;
        fin_next    = fin_cur;
        res_valid   = 1'b0;
        res_face    = '0;
        res_face.face_number = faces_cur;
        if (!fin_cur)
        begin
            res_valid  = 1'b1;
            faces_next = faces_cur + 1'b1;
            unique case (sec_cur)
                SEC_TOP:
                begin
                    res_face.vertex_a = '0;
                    res_face.vertex_b = e_inc;
                    res_face.vertex_c = e_wrap + VERTEX_W'(1);
                    side_next = side_cur + 1'b1;
                    if (side_last)
                    begin
                        side_next = '0;
                        lo_next   = hi_cur;
                        hi_next   = hi_cur + VERTEX_W'(SIDES);
                        ring_next = DIV_W'(1);
                        sec_next  = (n_reg >= DIV_W'(2)) ? SEC_UPPER : SEC_MIDDLE;
                    end
                end
                SEC_UPPER:
                begin
                    if (!par)
                    begin
                        res_face.vertex_a = v_lo_p;
                        res_face.vertex_b = v_hi_q;
                        res_face.vertex_c = v_hi_q1;
                    end
                    else
                    begin
                        res_face.vertex_a = v_lo_p1;
                        res_face.vertex_b = v_lo_p;
                        res_face.vertex_c = v_hi_q1;
                    end
                    if (step_cur < (STEP_W'(ring_cur) << 1))
                    begin
                        step_next = step_inc;
                    end
                    else
                    begin
                        step_next = '0;
                        side_next = side_cur + 1'b1;
                        if (side_last)
                        begin
                            side_next = '0;
                            lo_next   = hi_cur;
                            hi_next   = hi_cur + VERTEX_W'(ch);
                            if (mh < n_reg)
                            begin
                                ring_next = mh;
                            end
                            else
                            begin
                                sec_next  = SEC_MIDDLE;
                                ring_next = DIV_W'(1);
                            end
                        end
                    end
                end
                SEC_MIDDLE:
                begin
                    if (!par)
                    begin
                        res_face.vertex_a = v_lo_p;
                        res_face.vertex_b = v_hi_q;
                        res_face.vertex_c = v_lo_p1;
                        second_next = 1'b1;
                    end
                    else
                    begin
                        res_face.vertex_a = v_lo_p1;
                        res_face.vertex_b = v_hi_q;
                        res_face.vertex_c = v_hi_q1;
                        second_next = 1'b0;
                        step_next   = step_inc;
                        if (step_inc >= STEP_W'(n_reg))
                        begin
                            step_next = '0;
                            side_next = side_cur + 1'b1;
                            if (side_last)
                            begin
                                side_next = '0;
                                lo_next   = hi_cur;
                                hi_next   = hi_cur + VERTEX_W'(cl);
                                if (ring_cur < n_reg)
                                begin
                                    ring_next = ring_cur + 1'b1;
                                end
                                else if (n_reg >= DIV_W'(2))
                                begin
                                    sec_next  = SEC_LOWER;
                                    ring_next = n_reg - 1'b1;
                                end
                                else
                                begin
                                    sec_next = SEC_BOTTOM;
                                end
                            end
                        end
                    end
                end
                SEC_LOWER:
                begin
                    if (!par)
                    begin
                        res_face.vertex_a = v_lo_p;
                        res_face.vertex_b = v_hi_q;
                        res_face.vertex_c = v_lo_p1;
                    end
                    else
                    begin
                        res_face.vertex_a = v_lo_p1;
                        res_face.vertex_b = v_hi_q;
                        res_face.vertex_c = v_hi_q1;
                    end
                    if (step_cur < (STEP_W'(ring_cur) << 1))
                    begin
                        step_next = step_inc;
                    end
                    else
                    begin
                        step_next = '0;
                        side_next = side_cur + 1'b1;
                        if (side_last)
                        begin
                            side_next = '0;
                            lo_next   = hi_cur;
                            hi_next   = hi_cur + VERTEX_W'(ch);
                            if (ring_cur > DIV_W'(1))
                            begin
                                ring_next = ring_cur - 1'b1;
                            end
                            else
                            begin
                                sec_next = SEC_BOTTOM;
                            end
                        end
                    end
                end
                SEC_BOTTOM:
                begin
                    res_face.vertex_a = hi_cur;
                    res_face.vertex_b = hi_cur - e_inc;
                    res_face.vertex_c = hi_cur - e_wrap - VERTEX_W'(1);
                    if (side_last)
                    begin
                        res_face.last_face = 1'b1;
                        fin_next = 1'b1;
                    end
                    else
                    begin
                        side_next = side_cur + 1'b1;
                    end
                end
                default:
                begin
                    fin_next   = 1'b1;
                    res_valid  = 1'b0;
                    faces_next = faces_cur;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sec_reg    <= SEC_TOP;
            ring_reg   <= '0;
            side_reg   <= '0;
            step_reg   <= '0;
            second_reg <= 1'b0;
            lo_reg     <= '0;
            hi_reg     <= VERTEX_W'(1);
            faces_reg  <= '0;
            fin_reg    <= 1'b1;
            n_reg      <= DIV_W'(1);
        end
        else
        begin
            if (fire)
            begin
                sec_reg    <= sec_next;
                ring_reg   <= ring_next;
                side_reg   <= side_next;
                step_reg   <= step_next;
                second_reg <= second_next;
                lo_reg     <= lo_next;
                hi_reg     <= hi_next;
                faces_reg  <= faces_next;
                fin_reg    <= fin_next;
            end
            // a new division count stops the list until the next restart
            if (cfg_valid && cfg_ready)
            begin
                n_reg   <= n_next;
                fin_reg <= 1'b1;
            end
        end
    end

`ifndef ASSERT_OFF
    a_restart_face0: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.restart |-> res_valid && (res_face.face_number == '0))
        else $error("restart item did not give face zero");

    a_quiet_when_done: assert property (@(posedge clk) disable iff (!rst_n)
        fire && fin_reg && !item.restart |-> !res_valid)
        else $error("face produced after the list finished");

    a_last_stops: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res_valid && res_face.last_face |=> fin_reg)
        else $error("list still running after the last face");

    a_face_count: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res_valid |=>
            (faces_reg == FACE_NUM_W'($past(res_face.face_number) + 1'b1)))
        else $error("face count did not advance by one");
`endif

endmodule

### rtl/ifig_out_stage.sv
`timescale 1ns / 1ps

module ifig_out_stage
    import ifig_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire,
    input  logic                  res_valid,
    input  face_t                 res_face,
    output logic                  advance,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [15:0] vertex_a, [31:16] vertex_b, [47:32] vertex_c, [64:48] face_number, rest zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tlast
);

    logic  valid_reg;
    logic  valid_next;
    face_t face_reg;

    assign advance = !valid_reg || m_axis_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (fire)
        begin
            valid_next = res_valid;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && res_valid)
        begin
            face_reg <= res_face;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tlast  = face_reg.last_face;
    assign m_axis_tdata  = {{(OUT_DATA_W - 3 * VERTEX_W - FACE_NUM_W){1'b0}},
                            face_reg.face_number, face_reg.vertex_c,
                            face_reg.vertex_b, face_reg.vertex_a};

endmodule

### rtl/icosphere_face_index_generator_top.sv
`timescale 1ns / 1ps
// An accepted item is held in the input stage, its face formed combinationally and
// registered in the output stage; one item per cycle while m_axis_tready is high.
// Each item steps the ring counters once; small adds and 3-bit multiplies give its face.
// Reset (rst_n, asynchronous, active low): divisions 1, list finished; ticks give
// no face until an item with restart set begins the list at face zero.
module icosphere_face_index_generator_top
    import ifig_pkg::*;
#(
    parameter int MAX_DIVISIONS = MAX_DIVISIONS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_W-1:0]      cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [0] restart, rest zero
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [15:0] vertex_a, [31:16] vertex_b, [47:32] vertex_c, [64:48] face_number, rest zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tlast
);

    item_ctl_t item;
    logic      advance;
    logic      fire;
    logic      res_valid;
    face_t     res_face;

    ifig_in_stage u_in_stage (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .advance       (advance),
        .item          (item)
    );

    ifig_seq #(
        .MAX_DIVISIONS (MAX_DIVISIONS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .item      (item),
        .advance   (advance),
        .fire      (fire),
        .res_valid (res_valid),
        .res_face  (res_face)
    );

    ifig_out_stage u_out_stage (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (fire),
        .res_valid     (res_valid),
        .res_face      (res_face),
        .advance       (advance),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

### tb/face_list_checker.sv
`timescale 1ns / 1ps

module face_list_checker
    import ifig_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_W-1:0]      cfg_data,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    // [0] restart, rest zero
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [15:0] vertex_a, [31:16] vertex_b, [47:32] vertex_c, [64:48] face_number, rest zero
    input  logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  m_axis_tlast,
    output int                    error_count,
    output int                    pending,
    output int                    faces_checked
);

    typedef enum logic [2:0] {
        TOP_CAP,
        UPPER_RINGS,
        MIDDLE_BAND,
        LOWER_RINGS,
        BOTTOM_CAP
    } mesh_section_t;

    localparam int unsigned DIV_LIMIT = MAX_DIVISIONS_DEF;

    logic [CFG_W-1:0] edge_divisions;
    mesh_section_t    section;
    int unsigned      ring;
    int unsigned      side;
    int unsigned      step;
    bit               second_half;
    int unsigned      lower_start;
    int unsigned      upper_start;
    int unsigned      face_count;
    bit               list_done;

    face_t            expected_faces[$];

    function automatic int unsigned ring_pos(input int unsigned base, input int unsigned k,
                                             input int unsigned count);
        return base + ((k == 0) ? count - 1 : k - 1);
    endfunction

    function automatic void advance_ring(input int unsigned count);
        lower_start = upper_start;
        upper_start = upper_start + count;
    endfunction

    function automatic void rewind_list();
        section     = TOP_CAP;
        ring        = 0;
        side        = 0;
        step        = 0;
        second_half = 1'b0;
        lower_start = 0;
        upper_start = 1;
        face_count  = 0;
    endfunction

    function automatic bit next_face(input logic restart, output face_t face);
        int unsigned n, e, t, i, j, b0, h0, nlo, nhi;
        int unsigned va, vb, vc;
        bit          last;
        va   = 0;
        vb   = 0;
        vc   = 0;
        last = 1'b0;
        face = '0;
        if (restart)
        begin
            rewind_list();
            list_done = 1'b0;
        end
        if (list_done)
            return 1'b0;
        n = 32'(edge_divisions);
        if (n == 0)
            n = 1;
        if (n > DIV_LIMIT)
            n = DIV_LIMIT;
        e = side;
        t = step;
        case (section)
            TOP_CAP:
            begin
                va = 0;
                vb = e + 1;
                vc = ((e >= 4) ? 0 : e + 1) + 1;
                side = side + 1;
                if (side >= SIDES)
                begin
                    side = 0;
                    advance_ring(SIDES);
                    ring = 1;
                    section = (n >= 2) ? UPPER_RINGS : MIDDLE_BAND;
                end
            end
            UPPER_RINGS:
            begin
                i   = ring;
                nlo = 5 * i;
                nhi = 5 * i + 5;
                b0  = e * i;
                h0  = e * (i + 1);
                if (t == 0)
                begin
                    va = ring_pos(lower_start, b0, nlo);
                    vb = ring_pos(upper_start, h0, nhi);
                    vc = ring_pos(upper_start, h0 + 1, nhi);
                end
                else if (t[0])
                begin
                    j  = (t - 1) >> 1;
                    va = ring_pos(lower_start, b0 + j + 1, nlo);
                    vb = ring_pos(lower_start, b0 + j, nlo);
                    vc = ring_pos(upper_start, h0 + j + 1, nhi);
                end
                else
                begin
                    j  = (t >> 1) - 1;
                    va = ring_pos(lower_start, b0 + j + 1, nlo);
                    vb = ring_pos(upper_start, h0 + j + 1, nhi);
                    vc = ring_pos(upper_start, h0 + j + 2, nhi);
                end
                if (t < 2 * i)
                    step = t + 1;
                else
                begin
                    step = 0;
                    side = side + 1;
                    if (side >= SIDES)
                    begin
                        side = 0;
                        advance_ring(nhi);
                        if (i + 1 < n)
                            ring = i + 1;
                        else
                        begin
                            section = MIDDLE_BAND;
                            ring = 1;
                        end
                    end
                end
            end
            MIDDLE_BAND:
            begin
                nlo = 5 * n;
                j   = e * n + t;
                if (!second_half)
                begin
                    va = ring_pos(lower_start, j, nlo);
                    vb = ring_pos(upper_start, j, nlo);
                    vc = ring_pos(lower_start, j + 1, nlo);
                    second_half = 1'b1;
                end
                else
                begin
                    va = ring_pos(lower_start, j + 1, nlo);
                    vb = ring_pos(upper_start, j, nlo);
                    vc = ring_pos(upper_start, j + 1, nlo);
                    second_half = 1'b0;
                    step = step + 1;
                    if (step >= n)
                    begin
                        step = 0;
                        side = side + 1;
                        if (side >= SIDES)
                        begin
                            side = 0;
                            advance_ring(nlo);
                            if (ring < n)
                                ring = ring + 1;
                            else if (n >= 2)
                            begin
                                section = LOWER_RINGS;
                                ring = n - 1;
                            end
                            else
                                section = BOTTOM_CAP;
                        end
                    end
                end
            end
            LOWER_RINGS:
            begin
                i   = ring;
                nlo = 5 * i + 5;
                nhi = 5 * i;
                b0  = e * (i + 1);
                h0  = e * i;
                if (t == 0)
                begin
                    va = ring_pos(lower_start, b0, nlo);
                    vb = ring_pos(upper_start, h0, nhi);
                    vc = ring_pos(lower_start, b0 + 1, nlo);
                end
                else if (t[0])
                begin
                    j  = (t - 1) >> 1;
                    va = ring_pos(lower_start, b0 + j + 1, nlo);
                    vb = ring_pos(upper_start, h0 + j, nhi);
                    vc = ring_pos(upper_start, h0 + j + 1, nhi);
                end
                else
                begin
                    j  = (t >> 1) - 1;
                    va = ring_pos(lower_start, b0 + j + 1, nlo);
                    vb = ring_pos(upper_start, h0 + j + 1, nhi);
                    vc = ring_pos(lower_start, b0 + j + 2, nlo);
                end
                if (t < 2 * i)
                    step = t + 1;
                else
                begin
                    step = 0;
                    side = side + 1;
                    if (side >= SIDES)
                    begin
                        side = 0;
                        advance_ring(nhi);
                        if (i > 1)
                            ring = i - 1;
                        else
                            section = BOTTOM_CAP;
                    end
                end
            end
            BOTTOM_CAP:
            begin
                va = upper_start;
                vb = upper_start - e - 1;
                vc = upper_start - ((e >= 4) ? 0 : e + 1) - 1;
                if (e >= 4)
                begin
                    last = 1'b1;
                    list_done = 1'b1;
                end
                else
                    side = e + 1;
            end
            default:
            begin
                list_done = 1'b1;
                return 1'b0;
            end
        endcase
        face.vertex_a    = va[VERTEX_W-1:0];
        face.vertex_b    = vb[VERTEX_W-1:0];
        face.vertex_c    = vc[VERTEX_W-1:0];
        face.face_number = face_count[FACE_NUM_W-1:0];
        face.last_face   = last;
        face_count = face_count + 1;
        return 1'b1;
    endfunction

    task automatic check_field(input string field, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin : watch
        face_t want_face;
        face_t new_face;
        if (!rst_n)
        begin
            edge_divisions = 7'd1;
            rewind_list();
            list_done = 1'b1;
            expected_faces.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                edge_divisions = cfg_data;
                list_done = 1'b1;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                faces_checked++;
                if (expected_faces.size() == 0)
                begin
                    $error("face %0d arrived with none expected",
                           m_axis_tdata[64:48]);
                    error_count++;
                end
                else
                begin
                    want_face = expected_faces.pop_front();
                    check_field("vertex_a", 32'(want_face.vertex_a),
                                32'(m_axis_tdata[15:0]));
                    check_field("vertex_b", 32'(want_face.vertex_b),
                                32'(m_axis_tdata[31:16]));
                    check_field("vertex_c", 32'(want_face.vertex_c),
                                32'(m_axis_tdata[47:32]));
                    check_field("face_number", 32'(want_face.face_number),
                                32'(m_axis_tdata[64:48]));
                    check_field("last_face", 32'(want_face.last_face),
                                32'(m_axis_tlast));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (next_face(s_axis_tdata[0], new_face))
                    expected_faces.insert(expected_faces.size(), new_face);
            end
        end
        pending <= expected_faces.size();
    end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import ifig_pkg::*;

    localparam int DRAIN_CYCLES   = 6;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 1300;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_W-1:0]      cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;

    int error_count;
    int pending;
    int faces_checked;

    int items_sent;
    int settings_used;
    int burst_left;
    int idle_cycles;

    int ready_mode;
    int mode_left;
    int stall_left;
    int pattern_phase;

    icosphere_face_index_generator_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    face_list_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .error_count   (error_count),
        .pending       (pending),
        .faces_checked (faces_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    // receiver: switch at random among four stall patterns
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b1;
            ready_mode    <= 0;
            mode_left     <= 0;
            stall_left    <= 0;
            pattern_phase <= 0;
        end
        else
        begin
            pattern_phase <= (pattern_phase == 2) ? 0 : pattern_phase + 1;
            if (mode_left == 0)
            begin
                ready_mode <= $urandom_range(0, 3);
                mode_left  <= $urandom_range(20, 200);
            end
            else
                mode_left <= mode_left - 1;
            if (stall_left != 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left    <= stall_left - 1;
            end
            else
            begin
                case (ready_mode)
                    0: m_axis_tready <= 1'b1;
                    1:
                    begin
                        if ($urandom_range(0, 3) == 0)
                        begin
                            m_axis_tready <= 1'b0;
                            stall_left    <= $urandom_range(0, 3);
                        end
                        else
                            m_axis_tready <= 1'b1;
                    end
                    2: m_axis_tready <= (pattern_phase != 0);
                    default:
                    begin
                        if ($urandom_range(0, 2) == 0)
                        begin
                            m_axis_tready <= 1'b0;
                            stall_left    <= $urandom_range(4, 12);
                        end
                        else
                            m_axis_tready <= 1'b1;
                    end
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else
        begin
            if ((cfg_valid && cfg_ready) || (s_axis_tvalid && s_axis_tready)
                || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no item moved for %0d cycles", idle_cycles);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    task automatic send_tick(input logic restart);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_DATA_W-1){1'b0}}, restart};
        do
            @(posedge clk);
        while (!s_axis_tready);
        items_sent++;
    endtask

    // hold off until every face is out and the pipeline has emptied
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_divisions(input logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic run_mesh(input logic [CFG_W-1:0] value, input int ticks,
                            input int noise_ticks, input int restart_odds);
        settle();
        write_divisions(value);
        repeat (noise_ticks) send_tick(1'b0);
        send_tick(1'b1);
        for (int k = 1; k < ticks; k++)
            send_tick((restart_odds != 0) && ($urandom_range(1, restart_odds) == 1));
    endtask

    function automatic int face_total(input logic [CFG_W-1:0] value);
        int n;
        n = int'(value);
        if (n == 0)
            n = 1;
        if (n > MAX_DIVISIONS_DEF)
            n = MAX_DIVISIONS_DEF;
        return 20 * n * n;
    endfunction

    initial
    begin
        int                start_count;
        int                pick;
        int                faces;
        logic [CFG_W-1:0]  value;
        rst_n         <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_data      <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        items_sent    = 0;
        settings_used = 0;
        burst_left    = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ticks before any restart give nothing; then the reset setting, one full list
        send_tick(1'b0);
        send_tick(1'b0);
        send_tick(1'b1);
        repeat (19) send_tick(1'b0);
        send_tick(1'b0);
        send_tick(1'b0);

        run_mesh(7'd0, 22, 1, 0);
        run_mesh(7'd127, 150, 0, 40);
        run_mesh(7'd2, 83, 2, 0);
        run_mesh(7'd3, 180, 0, 0);

        start_count = items_sent;
        while (items_sent - start_count < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 13)
                value = CFG_W'($urandom_range(1, 4));
            else if (pick < 14)
                value = '0;
            else if (pick < 16)
                value = CFG_W'($urandom_range(65, 127));
            else
                value = CFG_W'($urandom_range(5, 127));
            faces = face_total(value);
            if (faces <= 320)
                run_mesh(value, faces + $urandom_range(0, 3),
                         ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0,
                         ($urandom_range(0, 2) == 0) ? 200 : 0);
            else
                run_mesh(value, $urandom_range(20, 200), 0, 60);
        end

        // largest mesh: top cap and the first upper rings
        run_mesh(7'd64, 240, 0, 0);
        run_mesh(7'd1, 21, 0, 0);
        settle();

        $display("%0d items sent across %0d edge_divisions settings", items_sent,
                 settings_used);
        $display("%0d faces compared, whole lists for small meshes, opening faces of large",
                 faces_checked);
        if (error_count == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
